@@ hdl/rvie_pkg.sv @@
// ----------------------------------------------------------------------------
// rvie_pkg
// Shared types, opcode constants and ALU function of the RV32IM execute unit.
// ----------------------------------------------------------------------------
package rvie_pkg;

	localparam int NUM_REGS_DEF = 32;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [6:0] OPC_LUI   = 7'b0110111;
	localparam logic [6:0] OPC_AUIPC = 7'b0010111;
	localparam logic [6:0] OPC_OPIMM = 7'b0010011;
	localparam logic [6:0] OPC_OP    = 7'b0110011;

	localparam logic [6:0] F7_BASE   = 7'h00;
	localparam logic [6:0] F7_MULDIV = 7'h01;
	localparam logic [6:0] F7_ALT    = 7'h20;

	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	localparam logic [2:0] F3_MUL  = 3'd0;

	typedef enum logic [2:0] {
		CLS_UNSUP,
		CLS_VALUE,
		CLS_ALU,
		CLS_MUL,
		CLS_DIV
	} op_class_t;

	typedef struct packed {
		op_class_t   cls;
		logic [2:0]  funct3;
		logic        alt;
		logic        use_imm;
		logic [31:0] imm;
		logic [4:0]  rd;
		logic [4:0]  rs1;
		logic [4:0]  rs2;
	} op_t;

	function automatic logic [31:0] alu_result(input logic [2:0] f3, input logic [31:0] a,
			input logic [31:0] b, input logic alt);
		logic [31:0] r;
		case (f3)
			F3_ADD:  r = alt ? (a - b) : (a + b);
			F3_SLL:  r = a << b[4:0];
			F3_SLT:  r = {31'b0, $signed(a) < $signed(b)};
			F3_SLTU: r = {31'b0, a < b};
			F3_XOR:  r = a ^ b;
			F3_SR:   r = alt ? 32'($signed(a) >>> b[4:0]) : (a >> b[4:0]);
			F3_OR:   r = a | b;
			F3_AND:  r = a & b;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ hdl/rvie_front.sv @@
// ----------------------------------------------------------------------------
// rvie_front
// Accepts instructions, decodes and classifies them into queue entries.
// ----------------------------------------------------------------------------
module rvie_front import rvie_pkg::*; (
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] instr_word,
	input  logic [31:0] instr_pc,
	input  logic        queue_full,
	output logic        push,
	output op_t         op
);

	logic [6:0] opc;
	logic [2:0] f3;
	logic [6:0] f7;

	assign opc      = instr_word[6:0];
	assign f3       = instr_word[14:12];
	assign f7       = instr_word[31:25];
	assign in_stall = queue_full;
	assign push     = in_valid && !queue_full;

	always_comb begin
		op         = '0;
		op.cls     = CLS_UNSUP;
		op.funct3  = f3;
		op.rd      = instr_word[11:7];
		op.rs1     = instr_word[19:15];
		op.rs2     = instr_word[24:20];
		op.imm     = {{20{instr_word[31]}}, instr_word[31:20]};
		case (opc)
			OPC_LUI: begin
				op.cls = CLS_VALUE;
				op.imm = {instr_word[31:12], 12'b0};
			end
			OPC_AUIPC: begin
				op.cls = CLS_VALUE;
				op.imm = instr_pc + {instr_word[31:12], 12'b0};
			end
			OPC_OPIMM: begin
				op.use_imm = 1'b1;
				op.alt     = (f3 == F3_SR) && (f7 == F7_ALT);
				if (f3 == F3_SLL) begin
					op.cls = (f7 == F7_BASE) ? CLS_ALU : CLS_UNSUP;
				end else if (f3 == F3_SR) begin
					op.cls = (f7 inside {F7_BASE, F7_ALT}) ? CLS_ALU : CLS_UNSUP;
				end else begin
					op.cls = CLS_ALU;
				end
			end
			OPC_OP: begin
				if (f7 == F7_BASE) begin
					op.cls = CLS_ALU;
				end else if (f7 == F7_MULDIV) begin
					op.cls = f3[2] ? CLS_DIV : CLS_MUL;
				end else if (f7 == F7_ALT && (f3 inside {F3_ADD, F3_SR})) begin
					op.cls = CLS_ALU;
					op.alt = 1'b1;
				end
			end
			default: op.cls = CLS_UNSUP;
		endcase
	end

endmodule

@@ hdl/rvie_queue.sv @@
// ----------------------------------------------------------------------------
// rvie_queue
// Small FIFO of decoded operations between front and back.
// ----------------------------------------------------------------------------
module rvie_queue import rvie_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  wdata,
	input  logic pop,
	output op_t  rdata,
	output logic full,
	output logic empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	op_t           store_q [DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = store_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hdl/rvie_back.sv @@
// ----------------------------------------------------------------------------
// rvie_back
// Register file, ALU, multiplier and radix-2 divider; drives the result port.
// ----------------------------------------------------------------------------
module rvie_back import rvie_pkg::*; #(
	parameter int NUM_REGS = NUM_REGS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        queue_empty,
	input  op_t         head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  dest_reg,
	output logic [31:0] write_value,
	output logic        write_enable,
	output logic        status
);

	localparam int IDX_W = $clog2(NUM_REGS);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_EXEC = 6'b000010,
		S_MUL  = 6'b000100,
		S_DIV  = 6'b001000,
		S_DFIN = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t        state_q;
	op_t           op_q;
	logic [31:0]   mem [NUM_REGS];
	logic [NUM_REGS-1:0] vld_q;
	logic [31:0]   rd1_q, rd2_q;
	logic          ok1_q, ok2_q;
	logic [31:0]   a, b, b_op;
	logic [32:0]   ax, bx;
	logic [63:0]   prod_q;
	logic [31:0]   quo_q, dvs_q, rem_q, a_q;
	logic [4:0]    cnt_q;
	logic          negq_q, negr_q, bzero_q;
	logic [32:0]   diff;
	logic          sgn;
	logic          fin, fin_ok, fin_we;
	logic [31:0]   fin_val;
	logic [4:0]    dest_q;
	logic [31:0]   value_q;
	logic          we_q, status_q;

	assign pop          = (state_q == S_IDLE) && !queue_empty;
	assign out_valid    = (state_q == S_OUT);
	assign dest_reg     = dest_q;
	assign write_value  = value_q;
	assign write_enable = we_q;
	assign status       = status_q;

	assign a    = ok1_q ? rd1_q : '0;
	assign b    = ok2_q ? rd2_q : '0;
	assign b_op = op_q.use_imm ? op_q.imm : b;
	assign sgn  = !op_q.funct3[0];
	assign ax   = {(op_q.funct3 == 3'd1 || op_q.funct3 == 3'd2) && a[31], a};
	assign bx   = {(op_q.funct3 == 3'd1) && b[31], b};
	assign diff = {rem_q, quo_q[31]} - {1'b0, dvs_q};

	always_comb begin
		fin     = 1'b0;
		fin_val = '0;
		case (state_q)
			S_EXEC: begin
				fin = (op_q.cls != CLS_MUL) && (op_q.cls != CLS_DIV);
				case (op_q.cls)
					CLS_VALUE: fin_val = op_q.imm;
					CLS_ALU:   fin_val = alu_result(op_q.funct3, a, b_op, op_q.alt);
					default:   fin_val = '0;
				endcase
			end
			S_MUL: begin
				fin     = 1'b1;
				fin_val = (op_q.funct3 == F3_MUL) ? prod_q[31:0] : prod_q[63:32];
			end
			S_DFIN: begin
				fin = 1'b1;
				if (bzero_q) begin
					fin_val = op_q.funct3[1] ? a_q : '1;
				end else if (op_q.funct3[1]) begin
					fin_val = negr_q ? (32'd0 - rem_q) : rem_q;
				end else begin
					fin_val = negq_q ? (32'd0 - quo_q) : quo_q;
				end
			end
			default: fin = 1'b0;
		endcase
	end

	assign fin_ok = (op_q.cls != CLS_UNSUP);
	assign fin_we = fin_ok && (op_q.rd != '0) && (32'(op_q.rd) < NUM_REGS);

	always_ff @(posedge clk) begin
		if (pop) begin
			op_q  <= head;
			rd1_q <= mem[head.rs1[IDX_W-1:0]];
			rd2_q <= mem[head.rs2[IDX_W-1:0]];
		end
		if (fin && fin_we) begin
			mem[op_q.rd[IDX_W-1:0]] <= fin_val;
		end
		if (fin) begin
			dest_q  <= fin_ok ? op_q.rd : '0;
			value_q <= fin_ok ? fin_val : '0;
		end
		if (state_q == S_EXEC && op_q.cls == CLS_MUL) begin
			prod_q <= 64'($signed(ax) * $signed(bx));
		end
		if (state_q == S_EXEC && op_q.cls == CLS_DIV) begin
			quo_q   <= (sgn && a[31]) ? (32'd0 - a) : a;
			dvs_q   <= (sgn && b[31]) ? (32'd0 - b) : b;
			rem_q   <= '0;
			a_q     <= a;
			bzero_q <= (b == '0);
			negq_q  <= sgn && (a[31] ^ b[31]);
			negr_q  <= sgn && a[31];
		end else if (state_q == S_DIV) begin
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			vld_q    <= '0;
			ok1_q    <= 1'b0;
			ok2_q    <= 1'b0;
			cnt_q    <= '0;
			we_q     <= 1'b0;
			status_q <= 1'b0;
		end else begin
			if (pop) begin
				ok1_q <= vld_q[head.rs1[IDX_W-1:0]] && (32'(head.rs1) < NUM_REGS);
				ok2_q <= vld_q[head.rs2[IDX_W-1:0]] && (32'(head.rs2) < NUM_REGS);
			end
			if (fin) begin
				we_q     <= fin_we;
				status_q <= !fin_ok;
				if (fin_we) begin
					vld_q[op_q.rd[IDX_W-1:0]] <= 1'b1;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					cnt_q <= '0;
					if (op_q.cls == CLS_MUL) begin
						state_q <= S_MUL;
					end else if (op_q.cls == CLS_DIV) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_MUL: state_q <= S_OUT;
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == '1) begin
						state_q <= S_DFIN;
					end
				end
				S_DFIN: state_q <= S_OUT;
				S_OUT: begin
					if (!out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ hdl/rv32im_integer_execute_unit.sv @@
// ----------------------------------------------------------------------------
// rv32im_integer_execute_unit
// RV32IM execute unit with private register file (LUI, AUIPC, OP-IMM, OP).
// ----------------------------------------------------------------------------
// Input channel: instr_word and instr_pc, handshake in_valid / in_stall.
// Output channel: dest_reg, write_value, write_enable, status, handshake
// out_valid / out_stall. One result transaction per input transaction,
// in order.
// The front decodes each instruction and pushes it into a two-entry queue;
// in_stall rises only when that queue is full, so new instructions are
// taken while a result waits on out_stall.
// The back executes one instruction at a time: ALU, LUI, AUIPC and
// unsupported ops go from execute straight to the result register,
// multiplies through one registered 33x33 multiply, divides and
// remainders through a radix-2 divider, one quotient bit per cycle.
// The back returns to idle on the accepting edge of a result and pops
// the next queued instruction on the following edge.
// Reset clears the control state and marks every register as zero.
// A stalled result holds on the output register until taken.
// ----------------------------------------------------------------------------
module rv32im_integer_execute_unit import rvie_pkg::*; #(
	parameter int NUM_REGS = NUM_REGS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] instr_word,
	input  logic [31:0] instr_pc,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  dest_reg,
	output logic [31:0] write_value,
	output logic        write_enable,
	output logic        status
);

	op_t  push_op, head_op;
	logic push, pop, q_full, q_empty;

	rvie_front u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.instr_word (instr_word),
		.instr_pc   (instr_pc),
		.queue_full (q_full),
		.push       (push),
		.op         (push_op)
	);

	rvie_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_op),
		.pop    (pop),
		.rdata  (head_op),
		.full   (q_full),
		.empty  (q_empty)
	);

	rvie_back #(.NUM_REGS(NUM_REGS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.queue_empty  (q_empty),
		.head         (head_op),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.dest_reg     (dest_reg),
		.write_value  (write_value),
		.write_enable (write_enable),
		.status       (status)
	);

endmodule

@@ hdl/rvie_checker.sv @@
// ----------------------------------------------------------------------------
// rvie_checker
// Port-level checks of the execute unit, bound to the top level.
// ----------------------------------------------------------------------------
module rvie_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [4:0]  dest_reg,
	input logic [31:0] write_value,
	input logic        write_enable,
	input logic        status
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(write_value) && $stable(status))
		else $error("stalled result transaction changed");

	a_unsup_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> !write_enable && write_value == 32'd0 && dest_reg == 5'd0)
		else $error("unsupported result carries data");

	a_no_x0: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_enable |-> dest_reg != 5'd0 && !status)
		else $error("write reported to x0 or with error status");

	a_stall_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> !out_valid)
		else $error("result transaction repeated");

endmodule

bind rv32im_integer_execute_unit rvie_checker u_rvie_checker (.*);
